[rtl/mf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_pkg: shared types and constants of the 3x3 median filter
// Register map, fixed field widths and the median-of-nine exchange network.
// ----------------------------------------------------------------------------
package mf_pkg;

	// configuration register widths
	localparam int FW_BITS       = 10;
	localparam int FH_BITS       = 13;
	localparam int BV_BITS       = 8;
	localparam int CFG_DATA_BITS = 13;
	localparam int CFG_IDX_BITS  = 2;

	// frame height limit and row counter width (room above the limit)
	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_BITS   = 14;

	// register reset values
	localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(512);
	localparam logic [FH_BITS-1:0] FH_RESET = FH_BITS'(512);
	localparam logic [BV_BITS-1:0] BV_RESET = BV_BITS'(128);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_BORDER_VALUE = 2'd2
	} mf_reg_t;

	// per-item control travelling beside the data through the median pipe
	typedef struct packed {
		logic valid;
		logic last;
	} mf_ctl_t;

	// exchange network: after both halves the median sits in MED_CENTRE
	localparam int MED_LO_N = 9;
	localparam int MED_HI_N = 10;
	localparam logic [3:0] MED_CENTRE = 4'd4;

	// first half: sort each row of three
	localparam logic [3:0] MED_LO_A [MED_LO_N] = '{4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6,
		4'd1, 4'd4, 4'd7};
	localparam logic [3:0] MED_LO_B [MED_LO_N] = '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7,
		4'd2, 4'd5, 4'd8};

	// second half: column max/min/median, then the final three
	localparam logic [3:0] MED_HI_A [MED_HI_N] = '{4'd0, 4'd5, 4'd4, 4'd3, 4'd1, 4'd2,
		4'd4, 4'd4, 4'd6, 4'd4};
	localparam logic [3:0] MED_HI_B [MED_HI_N] = '{4'd3, 4'd8, 4'd7, 4'd6, 4'd4, 4'd5,
		4'd7, 4'd2, 4'd4, 4'd2};

endpackage

[rtl/mf_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_in_if: pixel input channel
// Valid/ready channel carrying one pixel or flush tick per transfer.
// ----------------------------------------------------------------------------
interface mf_in_if #(
	parameter int PIXEL_BITS = 8
) ();
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [PIXEL_BITS-1:0] pixel;

	modport source (output valid, output action, output pixel, input ready);
	modport sink   (input valid, input action, input pixel, output ready);
endinterface

[rtl/mf_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_out_if: filtered pixel output channel
// Valid/ready channel carrying one median pixel and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface mf_out_if #(
	parameter int PIXEL_BITS = 8
) ();
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] out_pixel;
	logic                  last_of_frame;

	modport source (output valid, output out_pixel, output last_of_frame, input ready);
	modport sink   (input valid, input out_pixel, input last_of_frame, output ready);
endinterface

[rtl/mf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/mf_median9.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_median9: two-stage median-of-nine exchange network
// First half sorts the rows, second half picks the median; result registered.
// ----------------------------------------------------------------------------
module mf_median9 import mf_pkg::*; #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  mf_ctl_t               in_ctl,
	input  logic [PIXEL_BITS-1:0] nb [9],
	output mf_ctl_t               out_ctl,
	output logic [PIXEL_BITS-1:0] median
);
	logic [PIXEL_BITS-1:0] lo_v  [9];
	logic [PIXEL_BITS-1:0] hi_v  [9];
	logic [PIXEL_BITS-1:0] v_s2  [9];
	mf_ctl_t               ctl_s2;
	mf_ctl_t               ctl_q;
	logic [PIXEL_BITS-1:0] med_q;

	always_comb begin
		logic [PIXEL_BITS-1:0] t;
		t    = '0;
		lo_v = nb;
		for (int i = 0; i < MED_LO_N; i++) begin
			if (lo_v[MED_LO_A[i]] > lo_v[MED_LO_B[i]]) begin
				t                 = lo_v[MED_LO_A[i]];
				lo_v[MED_LO_A[i]] = lo_v[MED_LO_B[i]];
				lo_v[MED_LO_B[i]] = t;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_ctl.valid) begin
			v_s2 <= lo_v;
		end
	end

	always_comb begin
		logic [PIXEL_BITS-1:0] t;
		t    = '0;
		hi_v = v_s2;
		for (int i = 0; i < MED_HI_N; i++) begin
			if (hi_v[MED_HI_A[i]] > hi_v[MED_HI_B[i]]) begin
				t                 = hi_v[MED_HI_A[i]];
				hi_v[MED_HI_A[i]] = hi_v[MED_HI_B[i]];
				hi_v[MED_HI_B[i]] = t;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl_s2.valid) begin
			med_q <= hi_v[MED_CENTRE];
		end
	end

	assign out_ctl = ctl_q;
	assign median  = med_q;
endmodule

[rtl/median_filter_3x3_core.sv]
`timescale 1ns / 1ps
// Pipeline: a pixel that completes a neighbourhood gives its result through the line-store
//   read stage, the exchange network stage and the output register.
// Throughput: one input transfer per cycle; the line store takes one read and one write
//   each cycle. The whole pipe holds while a result waits on the output ready.
// Reset: counters, window and registers go to their defaults at once; the line store
//   needs no clearing pass, so the first transfer can follow reset directly.
// ----------------------------------------------------------------------------
// median_filter_3x3_core: streaming 3x3 median filter
// Raster pixel stream in, median of each 3x3 neighbourhood out, with
// configurable border fill and an end-of-frame mark on the final pixel.
// ----------------------------------------------------------------------------
module median_filter_3x3_core import mf_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int PIXEL_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	mf_in_if.sink                    in_ch,
	mf_out_if.source                 out_ch
);
	// column counter indexes the line store; width compare needs one bit more
	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int WB       = ($clog2(MAX_WIDTH + 1) > FW_BITS) ? $clog2(MAX_WIDTH + 1)
		: FW_BITS;

	// ---------------------------------------------------------------- config
	logic [FW_BITS-1:0] cfg_width_q;
	logic [FH_BITS-1:0] cfg_height_q;
	logic [BV_BITS-1:0] cfg_border_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= FW_RESET;
			cfg_height_q <= FH_RESET;
			cfg_border_q <= BV_RESET;
		end else if (cfg_we) begin
			unique case (mf_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  cfg_width_q  <= cfg_data[FW_BITS-1:0];
				REG_FRAME_HEIGHT: cfg_height_q <= cfg_data[FH_BITS-1:0];
				REG_BORDER_VALUE: cfg_border_q <= cfg_data[BV_BITS-1:0];
				default: ; // unmapped index: write dropped
			endcase
		end
	end

	// clamped frame size and border fill
	logic [WB-1:0]         fw_ext;
	logic [WB-1:0]         w_eff;
	logic [ROW_BITS-1:0]   fh_ext;
	logic [ROW_BITS-1:0]   h_eff;
	logic [PIXEL_BITS-1:0] bval;

	assign fw_ext = WB'(cfg_width_q);
	assign fh_ext = ROW_BITS'(cfg_height_q);
	assign bval   = PIXEL_BITS'(cfg_border_q);

	always_comb begin
		if (fw_ext < WB'(2)) begin
			w_eff = WB'(2);
		end else if (fw_ext > WB'(MAX_WIDTH)) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = fw_ext;
		end
		if (fh_ext < ROW_BITS'(2)) begin
			h_eff = ROW_BITS'(2);
		end else if (fh_ext > ROW_BITS'(MAX_HEIGHT)) begin
			h_eff = ROW_BITS'(MAX_HEIGHT);
		end else begin
			h_eff = fh_ext;
		end
	end

	// ---------------------------------------------------------------- flow control
	// One enable moves every stage; the input is ready whenever the output
	// register is empty or its result leaves in this cycle.
	mf_ctl_t out_ctl;
	logic    en;
	logic    accept;
	logic    idle_flush;
	logic    item_accept;

	assign en          = !out_ctl.valid || out_ch.ready;
	assign in_ch.ready = en;
	assign accept      = in_ch.valid && en;

	// ---------------------------------------------------------------- counters
	logic [COL_BITS-1:0] in_col_q;
	logic [ROW_BITS-1:0] in_row_q;
	logic [COL_BITS-1:0] out_col_q;
	logic [ROW_BITS-1:0] out_row_q;
	logic [COL_BITS-1:0] in_col_n;
	logic [ROW_BITS-1:0] in_row_n;
	logic [COL_BITS-1:0] out_col_n;
	logic [ROW_BITS-1:0] out_row_n;

	logic [WB-1:0]       in_col_p1;
	logic [WB-1:0]       out_col_x;
	logic [WB-1:0]       out_col_p1;
	logic [ROW_BITS-1:0] out_row_p1;

	assign in_col_p1  = WB'(in_col_q) + WB'(1);
	assign out_col_x  = WB'(out_col_q);
	assign out_col_p1 = out_col_x + WB'(1);
	assign out_row_p1 = out_row_q + ROW_BITS'(1);

	// a flush tick with no frame in progress is taken and dropped
	assign idle_flush  = in_ch.action && (in_row_q == '0) && (in_col_q == '0);
	assign item_accept = accept && !idle_flush;

	logic [PIXEL_BITS-1:0] item_value;
	logic                  item_emit;
	logic                  item_last;
	logic [2:0]            row_ok;
	logic [2:0]            col_ok;
	logic [8:0]            item_inside;

	// flush inside the frame and pixels below the frame store the border value
	assign item_value = (!in_ch.action && (in_row_q < h_eff)) ? in_ch.pixel : bval;
	assign item_emit  = (in_row_q >= ROW_BITS'(2)) ||
		((in_row_q == ROW_BITS'(1)) && (in_col_q != '0));
	assign item_last  = (out_row_p1 >= h_eff) && (out_col_p1 >= w_eff);

	// which neighbours of the output centre fall inside the frame
	assign row_ok[0] = (out_row_q != '0) && (out_row_q <= h_eff);
	assign row_ok[1] = out_row_q < h_eff;
	assign row_ok[2] = out_row_p1 < h_eff;
	assign col_ok[0] = (out_col_q != '0) && (out_col_x <= w_eff);
	assign col_ok[1] = out_col_x < w_eff;
	assign col_ok[2] = out_col_p1 < w_eff;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				item_inside[r*3+k] = row_ok[r] && col_ok[k];
			end
		end
	end

	always_comb begin
		if (in_col_p1 >= w_eff) begin
			in_col_n = '0;
			in_row_n = in_row_q + ROW_BITS'(1);
		end else begin
			in_col_n = COL_BITS'(in_col_p1);
			in_row_n = in_row_q;
		end
		out_col_n = out_col_q;
		out_row_n = out_row_q;
		if (item_emit) begin
			if (item_last) begin
				// frame done: everything restarts at the origin
				in_col_n  = '0;
				in_row_n  = '0;
				out_col_n = '0;
				out_row_n = '0;
			end else if (out_col_p1 >= w_eff) begin
				out_col_n = '0;
				out_row_n = out_row_p1;
			end else begin
				out_col_n = COL_BITS'(out_col_p1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (item_accept) begin
			in_col_q  <= in_col_n;
			in_row_q  <= in_row_n;
			out_col_q <= out_col_n;
			out_row_q <= out_row_n;
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Line-store read is in flight; the entry is rewritten when the item leaves.
	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] value_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic                  emit_s1;
	logic                  last_s1;
	logic [8:0]            inside_s1;
	logic                  byp_s1;
	logic [PIXEL_BITS-1:0] byp_top_s1;
	logic [PIXEL_BITS-1:0] byp_mid_s1;

	logic [PIXEL_BITS-1:0] top_s1;
	logic [PIXEL_BITS-1:0] mid_s1;
	logic                  ram_we;
	logic                  ram_hit;
	logic [2*PIXEL_BITS-1:0] ram_rdata;

	assign ram_we  = en && valid_s1;
	// same column read while the previous item writes it (first item after a frame end)
	assign ram_hit = valid_s1 && (col_s1 == in_col_q);

	assign top_s1 = byp_s1 ? byp_top_s1 : ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
	assign mid_s1 = byp_s1 ? byp_mid_s1 : ram_rdata[PIXEL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			value_s1   <= item_value;
			col_s1     <= in_col_q;
			emit_s1    <= item_emit;
			last_s1    <= item_last;
			inside_s1  <= item_inside;
			byp_s1     <= ram_hit;
			byp_top_s1 <= mid_s1;
			byp_mid_s1 <= value_s1;
		end
	end

	// each entry holds {row two above, row above} for its column
	mf_ram #(
		.WIDTH (2 * PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata ({mid_s1, value_s1}),
		.re    (item_accept),
		.raddr (in_col_q),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- window
	logic [PIXEL_BITS-1:0] window_q [9];
	logic [PIXEL_BITS-1:0] window_n [9];
	logic [PIXEL_BITS-1:0] nb       [9];
	mf_ctl_t               med_ctl;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			window_n[r*3]   = window_q[r*3+1];
			window_n[r*3+1] = window_q[r*3+2];
		end
		window_n[2] = top_s1;
		window_n[5] = mid_s1;
		window_n[8] = value_s1;
		for (int i = 0; i < 9; i++) begin
			nb[i] = inside_s1[i] ? window_n[i] : bval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				window_q[i] <= '0;
			end
		end else if (en && valid_s1) begin
			window_q <= window_n;
		end
	end

	assign med_ctl.valid = valid_s1 && emit_s1;
	assign med_ctl.last  = last_s1;

	// ---------------------------------------------------------------- median + output
	logic [PIXEL_BITS-1:0] median;

	mf_median9 #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_median (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (med_ctl),
		.nb      (nb),
		.out_ctl (out_ctl),
		.median  (median)
	);

	assign out_ch.valid         = out_ctl.valid;
	assign out_ch.out_pixel     = median;
	assign out_ch.last_of_frame = out_ctl.last;

	// ---------------------------------------------------------------- checks
	// the item that closes a frame leaves every counter at the origin
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		item_accept && item_emit && item_last |=>
			(in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0))
		else $error("counters not cleared after end of frame");

	// a read that meets a write at the same column must be served from the bypass
	a_store_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && item_accept && (col_s1 == in_col_q) |=> byp_s1)
		else $error("line store read-during-write not bypassed");

	// the end-of-frame mark only ever rides on a result
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |-> emit_s1)
		else $error("end-of-frame mark on an item without a result");

	// the bypass is only flagged when two consecutive items in stage 1 share a column
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && item_accept && !ram_hit |=> !byp_s1)
		else $error("spurious line store bypass");
endmodule

[bench/mf_bench_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_bench_pkg: codes shared by the median filter bench
// Input item kinds, used by the stimulus and by the checker.
// ----------------------------------------------------------------------------
package mf_bench_pkg;

	typedef enum logic {
		ACT_PIXEL = 1'b0,
		ACT_FLUSH = 1'b1
	} mf_action_t;

endpackage

[bench/mf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_checker: scoreboard for the 3x3 median filter
// Mirrors the filter state on every accepted input transfer, queues the
// expected median and compares each output transfer against it.
// ----------------------------------------------------------------------------
module mf_checker import mf_pkg::*, mf_bench_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int PIXEL_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	mf_in_if                         in_ch,
	mf_out_if                        out_ch,
	output int                       failures,
	output int                       outstanding,
	output int                       checked
);

	typedef struct packed {
		logic [PIXEL_BITS-1:0] level;
		logic                  last;
	} median_t;

	logic [FW_BITS-1:0]    reg_width;
	logic [FH_BITS-1:0]    reg_height;
	logic [BV_BITS-1:0]    reg_border;

	logic [PIXEL_BITS-1:0] store_far  [MAX_WIDTH];	// two rows back
	logic [PIXEL_BITS-1:0] store_near [MAX_WIDTH];	// one row back
	logic [PIXEL_BITS-1:0] tap [9];
	int unsigned           feed_col, feed_row, centre_col, centre_row;

	median_t               expected_medians [$];
	median_t               want;

	// one input item through the filter; queues a median when one falls due
	task automatic filter_step(input mf_action_t act, input logic [PIXEL_BITS-1:0] level);
		int unsigned           w, h;
		logic [PIXEL_BITS-1:0] fill, top, mid, val;
		logic [PIXEL_BITS-1:0] hood [9];
		logic                  emits;
		int                    rr, cc, below, same;
		median_t               res;
		w = (reg_width < 2) ? 2 : ((reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width);
		h = (reg_height < 2) ? 2 : ((reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height);
		fill = reg_border;
		// flush on an idle block
		if (act == ACT_FLUSH && feed_row == 0 && feed_col == 0)
			return;
		val = (act == ACT_PIXEL && feed_row < h) ? level : fill;
		top = '0;
		mid = '0;
		if (feed_col < MAX_WIDTH) begin
			top = store_far[feed_col];
			mid = store_near[feed_col];
			store_far[feed_col] = mid;
			store_near[feed_col] = val;
		end
		for (int r = 0; r < 3; r++) begin
			tap[r*3]   = tap[r*3+1];
			tap[r*3+1] = tap[r*3+2];
		end
		tap[2] = top;
		tap[5] = mid;
		tap[8] = val;
		emits = (feed_row >= 2) || (feed_row == 1 && feed_col >= 1);
		if (feed_col + 1 >= w) begin
			feed_col = 0;
			feed_row++;
		end else begin
			feed_col++;
		end
		if (!emits)
			return;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				rr = int'(centre_row) + r - 1;
				cc = int'(centre_col) + k - 1;
				hood[r*3+k] = (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) ?
					tap[r*3+k] : fill;
			end
		end
		// median: the entry with at most four below it and at least five at or below
		res.level = hood[0];
		for (int i = 0; i < 9; i++) begin
			below = 0;
			same = 0;
			for (int j = 0; j < 9; j++) begin
				if (hood[j] < hood[i])
					below++;
				else if (hood[j] == hood[i])
					same++;
			end
			if (below <= 4 && below + same >= 5)
				res.level = hood[i];
		end
		res.last = (centre_row + 1 >= h) && (centre_col + 1 >= w);
		expected_medians.push_back(res);
		if (res.last) begin
			feed_col = 0;
			feed_row = 0;
			centre_col = 0;
			centre_row = 0;
		end else if (centre_col + 1 >= w) begin
			centre_col = 0;
			centre_row++;
		end else begin
			centre_col++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_width = FW_RESET;
			reg_height = FH_RESET;
			reg_border = BV_RESET;
			foreach (store_far[i]) begin
				store_far[i] = '0;
				store_near[i] = '0;
			end
			foreach (tap[i])
				tap[i] = '0;
			feed_col = 0;
			feed_row = 0;
			centre_col = 0;
			centre_row = 0;
			expected_medians.delete();
			failures = 0;
			outstanding = 0;
			checked = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_medians.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("ERROR: unexpected median pixel=%0d last=%0b",
							out_ch.out_pixel, out_ch.last_of_frame);
				end else begin
					want = expected_medians.pop_front();
					checked++;
					if (out_ch.out_pixel !== want.level || out_ch.last_of_frame !== want.last) begin
						failures++;
						if (failures <= 10)
							$display("ERROR: median %0d expected pixel=%0d last=%0b, got pixel=%0d last=%0b",
								checked, want.level, want.last, out_ch.out_pixel,
								out_ch.last_of_frame);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  reg_width = cfg_data[FW_BITS-1:0];
					REG_FRAME_HEIGHT: reg_height = cfg_data[FH_BITS-1:0];
					REG_BORDER_VALUE: reg_border = cfg_data[BV_BITS-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				filter_step(mf_action_t'(in_ch.action), in_ch.pixel);
			outstanding = expected_medians.size();
		end
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for median_filter_3x3_core
// Short directed frames, two cut-short extreme-size frames, then random frames
// with random geometry, border fill and mid-frame reshaping; the checker scores.
// ----------------------------------------------------------------------------
module testbench;
	import mf_pkg::*;
	import mf_bench_pkg::*;

	localparam int MAX_WIDTH     = 512;
	localparam int PIXEL_BITS    = 8;
	localparam int CYCLE_LIMIT   = 200_000;
	localparam int RANDOM_ITEMS  = 800;
	localparam int SETTLE_CYCLES = 8;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	mf_in_if  #(.PIXEL_BITS(PIXEL_BITS)) pix_in  ();
	mf_out_if #(.PIXEL_BITS(PIXEL_BITS)) pix_out ();

	int          failures, outstanding, checked;
	int          cycles = 0;
	int          items_sent = 0, flushes_sent = 0, idle_sent = 0;
	int          reg_writes = 0, frames_done = 0;
	int unsigned eff_w = 512, eff_h = 512;	// clamped geometry, for item counts only
	bit          in_calm = 1'b0, out_calm = 1'b0;

	median_filter_3x3_core #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (pix_in),
		.out_ch    (pix_out)
	);

	mf_checker #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_ch       (pix_in),
		.out_ch      (pix_out),
		.failures    (failures),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop if the pipe locks up or a median never shows
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// random gap before a transfer, with occasional calm stretches of none
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	// grey levels with the two rails weighted up
	function automatic logic [PIXEL_BITS-1:0] draw_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIXEL_BITS'($urandom);
		endcase
	endfunction

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// one input transfer; valid stays high into the next call when there is no gap
	task automatic send_item(input mf_action_t act, input logic [PIXEL_BITS-1:0] level);
		int gap;
		gap = draw_wait(in_calm);
		@(negedge clk);
		if (gap != 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in.valid  <= 1'b1;
		pix_in.action <= act;
		pix_in.pixel  <= level;
		do @(posedge clk); while (!pix_in.ready);
		items_sent++;
		if (act == ACT_FLUSH)
			flushes_sent++;
	endtask

	// drop valid, let every queued median out, then give the pipe time to empty
	task automatic wait_drained();
		@(negedge clk);
		pix_in.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write; only issued with the block idle
	task automatic write_reg(input mf_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			REG_FRAME_WIDTH:  eff_w = clamp_dim(data[FW_BITS-1:0], 2, MAX_WIDTH);
			REG_FRAME_HEIGHT: eff_h = clamp_dim(data[FH_BITS-1:0], 2, MAX_HEIGHT);
			default: ;
		endcase
	endtask

	// full frame: W*H items with the odd flush inside the frame (never first),
	// then W+1 trailing items - pixels there sit below the frame and act as flushes
	task automatic stream_frame();
		int unsigned n;
		n = eff_w * eff_h;
		for (int unsigned i = 0; i < n; i++) begin
			if (i != 0 && $urandom_range(0, 29) == 0)
				send_item(ACT_FLUSH, draw_level());
			else
				send_item(ACT_PIXEL, draw_level());
		end
		for (int unsigned i = 0; i <= eff_w; i++)
			send_item(($urandom_range(0, 3) == 0) ? ACT_PIXEL : ACT_FLUSH, draw_level());
	endtask

	// stop part way (results already flowing), reshape while idle, then flush
	// until the frame closes; width may only shrink so every line-store entry
	// read inside the frame has been written
	task automatic cut_and_close(input int unsigned k, input int unsigned w_max,
		input int unsigned h_max);
		int unsigned seen;
		repeat (k) send_item(ACT_PIXEL, draw_level());
		wait_drained();
		write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'($urandom_range(0, w_max)));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'($urandom_range(0, h_max)));
		write_reg(REG_BORDER_VALUE, CFG_DATA_BITS'($urandom_range(0, 255)));
		seen = frames_done;
		// overshoot flushes land on an idle block and are dropped
		while (frames_done == seen)
			send_item(ACT_FLUSH, draw_level());
	endtask

	// output side: random stall before each result, ready held until the transfer
	initial begin
		int stall;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(out_calm);
			@(negedge clk);
			if (stall != 0) begin
				pix_out.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pix_out.ready <= 1'b1;
			do @(posedge clk); while (!pix_out.valid);
			if (pix_out.last_of_frame)
				frames_done++;
		end
	end

	initial begin
		int unsigned base, k, w_raw, h_raw, b_raw;
		pix_in.valid  = 1'b0;
		pix_in.action = ACT_PIXEL;
		pix_in.pixel  = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_FRAME_WIDTH;
		cfg_data      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed: 3x2 frame, black border
		write_reg(REG_FRAME_WIDTH, 13'd3);
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		write_reg(REG_BORDER_VALUE, 13'd0);
		send_item(ACT_FLUSH, 8'hFF);	// nothing in progress: must be dropped
		idle_sent++;
		send_item(ACT_PIXEL, 8'hFF);
		send_item(ACT_PIXEL, 8'h00);
		send_item(ACT_PIXEL, 8'hFF);
		send_item(ACT_FLUSH, 8'hFF);	// inside the frame: stored as border fill
		send_item(ACT_PIXEL, 8'h00);
		send_item(ACT_PIXEL, 8'hFF);
		repeat (4) send_item(ACT_FLUSH, 8'h00);
		wait_drained();

		// --- directed: 2x3 frame, white border; width written with high data bits set
		write_reg(REG_FRAME_WIDTH, 13'h1C02);
		write_reg(REG_FRAME_HEIGHT, 13'd3);
		write_reg(REG_BORDER_VALUE, 13'd255);
		send_item(ACT_PIXEL, 8'h00);
		send_item(ACT_PIXEL, 8'h00);
		send_item(ACT_PIXEL, 8'h80);
		send_item(ACT_PIXEL, 8'hFF);
		send_item(ACT_PIXEL, 8'h00);
		send_item(ACT_PIXEL, 8'h01);
		send_item(ACT_PIXEL, 8'hFF);	// below the last row: treated as a flush
		send_item(ACT_FLUSH, 8'h55);
		send_item(ACT_PIXEL, 8'h00);
		wait_drained();

		// --- widest frame (1023 clamps to 512, height 1 clamps to 2): one full row
		// and the start of the next, then cut down to a narrow frame and closed
		write_reg(REG_FRAME_WIDTH, 13'h03FF);
		write_reg(REG_FRAME_HEIGHT, 13'd1);
		write_reg(REG_BORDER_VALUE, CFG_DATA_BITS'($urandom_range(0, 255)));
		cut_and_close(eff_w + 1 + $urandom_range(0, 15), 8, 4);
		wait_drained();

		// --- tallest frame (width 0 clamps to 2, 8191 rows clamp to 4096): a run of
		// rows, then cut down in height and closed
		write_reg(REG_FRAME_WIDTH, 13'h1C00);
		write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
		write_reg(REG_BORDER_VALUE, CFG_DATA_BITS'($urandom_range(0, 255)));
		cut_and_close($urandom_range(4, 60), 2, 8);
		wait_drained();

		// --- random frames, mostly small
		base = items_sent - idle_sent;
		while (items_sent - idle_sent - base < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: w_raw = $urandom_range(0, 1);
				1: w_raw = $urandom_range(9, 40);
				default: w_raw = $urandom_range(2, 8);
			endcase
			case ($urandom_range(0, 9))
				0: h_raw = $urandom_range(0, 1);
				1: h_raw = $urandom_range(7, 16);
				default: h_raw = $urandom_range(2, 6);
			endcase
			case ($urandom_range(0, 5))
				0: b_raw = 0;
				1: b_raw = 255;
				default: b_raw = $urandom_range(0, 255);
			endcase
			// sometimes a register keeps its old value
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_FRAME_WIDTH, {3'($urandom), 10'(w_raw)});
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_FRAME_HEIGHT, 13'(h_raw));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_BORDER_VALUE, {5'($urandom), 8'(b_raw)});

			// stray flushes on an idle block are dropped
			repeat ($urandom_range(0, 2)) begin
				send_item(ACT_FLUSH, draw_level());
				idle_sent++;
			end

			if (eff_h >= 3 && $urandom_range(0, 7) == 0) begin
				// stop past row 1, reshape, flush until the frame closes
				k = $urandom_range(2 * eff_w, eff_w * eff_h - 1);
				cut_and_close(k, eff_w, 8);
			end else begin
				stream_frame();
			end
			wait_drained();
		end

		$display("Summary: %0d frames closed, %0d input transfers (%0d flush ticks,",
			frames_done, items_sent, flushes_sent);
		$display("Summary: %0d on an idle block), %0d medians checked, %0d register writes",
			idle_sent, checked, reg_writes);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
